@@ hdl/ddsm_pkg.sv @@
// Package for the differential-drive servo mixer.
// Holds shared widths, register indexes, the configuration bundle and the stage control type.
// No dependencies.
package ddsm_pkg;

    localparam int SERIAL_BUS_MODE_DEFAULT = 0;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam int SPEED_W   = 16;
    localparam int GAIN_W    = 16;
    localparam int PROD_W    = 32;
    localparam int SUM_W     = PROD_W + 1;
    localparam int FRAC_W    = 20;
    localparam int MAG_W     = SUM_W - FRAC_W;
    localparam int OFFSET_W  = MAG_W + 1;
    localparam int PULSE_W   = 12;
    localparam int DRIVE_W   = 13;
    localparam int WIDE_W    = OFFSET_W + 1;
    localparam int BAND_W    = 8;
    localparam int TIMEOUT_W = 16;
    localparam int ELAPSED_W = 17;

    localparam int BUS_LIMIT = 1023;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_LINEAR_GAIN   = 3'd0,
        REG_ANGULAR_GAIN  = 3'd1,
        REG_LEFT_CENTER   = 3'd2,
        REG_RIGHT_CENTER  = 3'd3,
        REG_DEAD_BAND     = 3'd4,
        REG_PULSE_MIN     = 3'd5,
        REG_PULSE_MAX     = 3'd6,
        REG_TIMEOUT_TICKS = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic [GAIN_W-1:0]    linear_gain;
        logic [GAIN_W-1:0]    angular_gain;
        logic [PULSE_W-1:0]   left_center;
        logic [PULSE_W-1:0]   right_center;
        logic [BAND_W-1:0]    dead_band;
        logic [PULSE_W-1:0]   pulse_min;
        logic [PULSE_W-1:0]   pulse_max;
        logic [TIMEOUT_W-1:0] timeout_ticks;
    } cfg_t;

    // Control that travels with an item down the pipeline.
    typedef struct packed {
        logic valid;
        logic is_stop;
    } stage_ctl_t;

endpackage

@@ hdl/ddsm_cfg_regs.sv @@
// Configuration register file of the servo mixer.
// Depends on ddsm_pkg for the register indexes and the cfg_t bundle.
module ddsm_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [ddsm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ddsm_pkg::CFG_DATA_W-1:0]  cfg_data,
    output ddsm_pkg::cfg_t                 cfg
);
    import ddsm_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index_t'(cfg_index))
                REG_LINEAR_GAIN:   cfg_next.linear_gain   = cfg_data;
                REG_ANGULAR_GAIN:  cfg_next.angular_gain  = cfg_data;
                REG_LEFT_CENTER:   cfg_next.left_center   = cfg_data[PULSE_W-1:0];
                REG_RIGHT_CENTER:  cfg_next.right_center  = cfg_data[PULSE_W-1:0];
                REG_DEAD_BAND:     cfg_next.dead_band     = cfg_data[BAND_W-1:0];
                REG_PULSE_MIN:     cfg_next.pulse_min     = cfg_data[PULSE_W-1:0];
                REG_PULSE_MAX:     cfg_next.pulse_max     = cfg_data[PULSE_W-1:0];
                REG_TIMEOUT_TICKS: cfg_next.timeout_ticks = cfg_data[TIMEOUT_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.linear_gain   <= GAIN_W'(256);
            cfg_reg.angular_gain  <= GAIN_W'(256);
            cfg_reg.left_center   <= PULSE_W'(1500);
            cfg_reg.right_center  <= PULSE_W'(1500);
            cfg_reg.dead_band     <= '0;
            cfg_reg.pulse_min     <= PULSE_W'(1000);
            cfg_reg.pulse_max     <= PULSE_W'(2000);
            cfg_reg.timeout_ticks <= TIMEOUT_W'(500);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ hdl/ddsm_timer.sv @@
// Input stage of the servo mixer: registers an accepted item and runs the command timeout.
// Depends on ddsm_pkg for widths and the stage control type.
module ddsm_timer (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                advance,
    input  logic                                accept,
    input  logic                                action,
    input  logic signed [ddsm_pkg::SPEED_W-1:0] linear_speed,
    input  logic signed [ddsm_pkg::SPEED_W-1:0] turn_rate,
    input  logic [ddsm_pkg::TIMEOUT_W-1:0]      timeout_ticks,
    output ddsm_pkg::stage_ctl_t                ctl,
    output logic signed [ddsm_pkg::SPEED_W-1:0] lin,
    output logic signed [ddsm_pkg::SPEED_W-1:0] turn
);
    import ddsm_pkg::*;

    logic                  armed_reg, armed_next;
    logic [ELAPSED_W-1:0]  elapsed_reg, elapsed_next;
    logic [ELAPSED_W-1:0]  elapsed_inc;
    stage_ctl_t            ctl_reg, ctl_next;
    logic signed [SPEED_W-1:0] lin_reg, turn_reg;

    always_comb
    begin
        armed_next   = armed_reg;
        elapsed_next = elapsed_reg;
        ctl_next     = ctl_reg;
        elapsed_inc  = (elapsed_reg == {ELAPSED_W{1'b1}}) ? elapsed_reg
                                                          : elapsed_reg + 1'b1;
        if (advance)
        begin
            ctl_next.valid   = 1'b0;
            ctl_next.is_stop = 1'b0;
            if (accept)
            begin
                if (!action)
                begin
                    // A command always rearms and restarts the count.
                    armed_next       = 1'b1;
                    elapsed_next     = '0;
                    ctl_next.valid   = 1'b1;
                end
                else if (armed_reg)
                begin
                    elapsed_next = elapsed_inc;
                    if (elapsed_inc > {1'b0, timeout_ticks})
                    begin
                        armed_next       = 1'b0;
                        ctl_next.valid   = 1'b1;
                        ctl_next.is_stop = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg   <= 1'b0;
            elapsed_reg <= '0;
            ctl_reg     <= '0;
        end
        else
        begin
            armed_reg   <= armed_next;
            elapsed_reg <= elapsed_next;
            ctl_reg     <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            lin_reg  <= linear_speed;
            turn_reg <= turn_rate;
        end
    end

    assign ctl  = ctl_reg;
    assign lin  = lin_reg;
    assign turn = turn_reg;

endmodule

@@ hdl/ddsm_mix.sv @@
// Mixing stages: the two gain products, then the wheel offsets with truncation and pulse-mode dead band.
// Depends on ddsm_pkg for widths and the stage control type.
module ddsm_mix #(
    parameter int SERIAL_BUS_MODE = ddsm_pkg::SERIAL_BUS_MODE_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 advance,
    input  ddsm_pkg::stage_ctl_t                 ctl_in,
    input  logic signed [ddsm_pkg::SPEED_W-1:0]  lin,
    input  logic signed [ddsm_pkg::SPEED_W-1:0]  turn,
    input  logic [ddsm_pkg::GAIN_W-1:0]          linear_gain,
    input  logic [ddsm_pkg::GAIN_W-1:0]          angular_gain,
    input  logic [ddsm_pkg::BAND_W-1:0]          dead_band,
    output ddsm_pkg::stage_ctl_t                 ctl_out,
    output logic signed [ddsm_pkg::OFFSET_W-1:0] off_left,
    output logic signed [ddsm_pkg::OFFSET_W-1:0] off_right
);
    import ddsm_pkg::*;

    // Shift right by the fraction width, rounding toward zero, and apply the dead band if use_band is set.
    function automatic logic signed [OFFSET_W-1:0] to_offset(
        input logic signed [SUM_W-1:0] s,
        input logic [BAND_W-1:0]       band,
        input logic                    use_band
    );
        logic [SUM_W-1:0]          mag_full;
        logic [MAG_W-1:0]          mag;
        logic signed [OFFSET_W-1:0] res;
        mag_full = s[SUM_W-1] ? SUM_W'(-s) : SUM_W'(s);
        mag      = mag_full[SUM_W-1:FRAC_W];
        res      = s[SUM_W-1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        if (use_band && (mag < {{(MAG_W-BAND_W){1'b0}}, band}))
        begin
            res = '0;
        end
        return res;
    endfunction

    localparam logic USE_BAND = (SERIAL_BUS_MODE == 0);

    stage_ctl_t                 ctl_b_reg, ctl_c_reg, ctl_c_next;
    logic signed [PROD_W-1:0]   plin_reg, pang_reg;
    logic signed [SUM_W:0]      plin_full, pang_full;
    logic signed [SUM_W-1:0]    sum_l, sum_r;
    logic signed [OFFSET_W-1:0] off_l_next, off_r_next;
    logic signed [OFFSET_W-1:0] off_l_reg, off_r_reg;

    assign plin_full = lin  * $signed({1'b0, linear_gain});
    assign pang_full = turn * $signed({1'b0, angular_gain});

    assign sum_l = {plin_reg[PROD_W-1], plin_reg} - {pang_reg[PROD_W-1], pang_reg};
    assign sum_r = {plin_reg[PROD_W-1], plin_reg} + {pang_reg[PROD_W-1], pang_reg};

    always_comb
    begin
        off_l_next = to_offset(sum_l, dead_band, USE_BAND);
        off_r_next = to_offset(sum_r, dead_band, USE_BAND);
        ctl_c_next = ctl_b_reg;
        // In pulse mode a command with no motion left on either wheel detaches.
        if (USE_BAND && (off_l_next == '0) && (off_r_next == '0))
        begin
            ctl_c_next.is_stop = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_b_reg <= '0;
            ctl_c_reg <= '0;
        end
        else if (advance)
        begin
            ctl_b_reg <= ctl_in;
            ctl_c_reg <= ctl_c_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            plin_reg  <= plin_full[PROD_W-1:0];
            pang_reg  <= pang_full[PROD_W-1:0];
            off_l_reg <= off_l_next;
            off_r_reg <= off_r_next;
        end
    end

    assign ctl_out   = ctl_c_reg;
    assign off_left  = off_l_reg;
    assign off_right = off_r_reg;

endmodule

@@ hdl/ddsm_drive.sv @@
// Output stage: turns wheel offsets into clamped pulses or bus speeds, held in the result register.
// Depends on ddsm_pkg for widths, limits and the stage control type.
module ddsm_drive #(
    parameter int SERIAL_BUS_MODE = ddsm_pkg::SERIAL_BUS_MODE_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 advance,
    input  ddsm_pkg::stage_ctl_t                 ctl_in,
    input  logic signed [ddsm_pkg::OFFSET_W-1:0] off_left,
    input  logic signed [ddsm_pkg::OFFSET_W-1:0] off_right,
    input  logic [ddsm_pkg::PULSE_W-1:0]         left_center,
    input  logic [ddsm_pkg::PULSE_W-1:0]         right_center,
    input  logic [ddsm_pkg::PULSE_W-1:0]         pulse_min,
    input  logic [ddsm_pkg::PULSE_W-1:0]         pulse_max,
    output logic                                 out_valid,
    output logic signed [ddsm_pkg::DRIVE_W-1:0]  left_drive,
    output logic signed [ddsm_pkg::DRIVE_W-1:0]  right_drive,
    output logic                                 enabled,
    output logic                                 stopped_now
);
    import ddsm_pkg::*;

    // With inverted limits, a value below the low limit takes the low limit and
    // every other value takes the high limit.
    function automatic logic signed [DRIVE_W-1:0] clamp_pulse(
        input logic signed [WIDE_W-1:0] x,
        input logic [PULSE_W-1:0]       lo,
        input logic [PULSE_W-1:0]       hi
    );
        logic signed [WIDE_W-1:0] lo_s;
        logic signed [WIDE_W-1:0] hi_s;
        logic signed [WIDE_W-1:0] res;
        lo_s = $signed({{(WIDE_W-PULSE_W){1'b0}}, lo});
        hi_s = $signed({{(WIDE_W-PULSE_W){1'b0}}, hi});
        if (x < lo_s)
        begin
            res = lo_s;
        end
        else if (x > hi_s)
        begin
            res = hi_s;
        end
        else
        begin
            res = x;
        end
        return res[DRIVE_W-1:0];
    endfunction

    function automatic logic signed [DRIVE_W-1:0] clamp_bus(
        input logic signed [WIDE_W-1:0] x
    );
        logic signed [WIDE_W-1:0] res;
        if (x < -WIDE_W'(BUS_LIMIT))
        begin
            res = -WIDE_W'(BUS_LIMIT);
        end
        else if (x > WIDE_W'(BUS_LIMIT))
        begin
            res = WIDE_W'(BUS_LIMIT);
        end
        else
        begin
            res = x;
        end
        return res[DRIVE_W-1:0];
    endfunction

    logic signed [WIDE_W-1:0]  off_l_w, off_r_w;
    logic signed [WIDE_W-1:0]  pulse_l, pulse_r;
    logic signed [DRIVE_W-1:0] left_next, right_next;
    logic                      valid_reg;
    logic signed [DRIVE_W-1:0] left_reg, right_reg;
    logic                      enabled_reg, stopped_reg;

    assign off_l_w = {off_left[OFFSET_W-1], off_left};
    assign off_r_w = {off_right[OFFSET_W-1], off_right};
    assign pulse_l = $signed({{(WIDE_W-PULSE_W){1'b0}}, left_center}) + off_l_w;
    assign pulse_r = $signed({{(WIDE_W-PULSE_W){1'b0}}, right_center}) - off_r_w;

    always_comb
    begin
        if (ctl_in.is_stop)
        begin
            left_next  = '0;
            right_next = '0;
        end
        else if (SERIAL_BUS_MODE != 0)
        begin
            left_next  = clamp_bus(off_l_w);
            right_next = clamp_bus(-off_r_w);
        end
        else
        begin
            left_next  = clamp_pulse(pulse_l, pulse_min, pulse_max);
            right_next = clamp_pulse(pulse_r, pulse_min, pulse_max);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= ctl_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            left_reg    <= left_next;
            right_reg   <= right_next;
            enabled_reg <= !ctl_in.is_stop;
            stopped_reg <= ctl_in.is_stop;
        end
    end

    assign out_valid   = valid_reg;
    assign left_drive  = left_reg;
    assign right_drive = right_reg;
    assign enabled     = enabled_reg;
    assign stopped_now = stopped_reg;

endmodule

@@ hdl/diff_drive_servo_mixer.sv @@
// Differential-drive servo mixer, top level.
// A result reaches out_valid through the timer, product, offset and result registers in turn.
// Throughput: one item per cycle unless a result is stalled; multiply, offset and clamp stages are registered.
// A stalled result holds the whole pipeline, so in_stall follows the result register.
// Reset (rst_n, asynchronous): pipeline empty, timer disarmed, registers at their defaults.
// Depends on ddsm_pkg and on ddsm_cfg_regs, ddsm_timer, ddsm_mix and ddsm_drive.
module diff_drive_servo_mixer #(
    parameter int SERIAL_BUS_MODE = ddsm_pkg::SERIAL_BUS_MODE_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration write port.
    input  logic                                cfg_write,
    input  logic [ddsm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ddsm_pkg::CFG_DATA_W-1:0]     cfg_data,
    // Input items: velocity commands and millisecond ticks.
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                action,
    input  logic signed [ddsm_pkg::SPEED_W-1:0] linear_speed,
    input  logic signed [ddsm_pkg::SPEED_W-1:0] turn_rate,
    // Result items.
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [ddsm_pkg::DRIVE_W-1:0] left_drive,
    output logic signed [ddsm_pkg::DRIVE_W-1:0] right_drive,
    output logic                                enabled,
    output logic                                stopped_now
);
    import ddsm_pkg::*;

    cfg_t                       cfg;
    stage_ctl_t                 ctl_a, ctl_c;
    logic signed [SPEED_W-1:0]  lin, turn;
    logic signed [OFFSET_W-1:0] off_left, off_right;
    logic                       advance;
    logic                       accept;

    // Every stage moves together unless a finished result is still waiting to be taken.
    // Ticks that produce no result travel as empty slots, so ordering is preserved.
    assign advance  = !(out_valid && out_stall);
    assign in_stall = !advance;
    assign accept   = in_valid && advance;

    ddsm_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // The timeout decision is taken as the item is accepted; it depends only on
    // the order of commands and ticks, never on the arithmetic further down.
    ddsm_timer u_timer (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .accept        (accept),
        .action        (action),
        .linear_speed  (linear_speed),
        .turn_rate     (turn_rate),
        .timeout_ticks (cfg.timeout_ticks),
        .ctl           (ctl_a),
        .lin           (lin),
        .turn          (turn)
    );

    // Two registered stages: the gain products, then the wheel offsets.
    ddsm_mix #(
        .SERIAL_BUS_MODE (SERIAL_BUS_MODE)
    ) u_mix (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .ctl_in       (ctl_a),
        .lin          (lin),
        .turn         (turn),
        .linear_gain  (cfg.linear_gain),
        .angular_gain (cfg.angular_gain),
        .dead_band    (cfg.dead_band),
        .ctl_out      (ctl_c),
        .off_left     (off_left),
        .off_right    (off_right)
    );

    // Final stage: pulse or bus clamping, feeding the result register.
    ddsm_drive #(
        .SERIAL_BUS_MODE (SERIAL_BUS_MODE)
    ) u_drive (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .ctl_in       (ctl_c),
        .off_left     (off_left),
        .off_right    (off_right),
        .left_center  (cfg.left_center),
        .right_center (cfg.right_center),
        .pulse_min    (cfg.pulse_min),
        .pulse_max    (cfg.pulse_max),
        .out_valid    (out_valid),
        .left_drive   (left_drive),
        .right_drive  (right_drive),
        .enabled      (enabled),
        .stopped_now  (stopped_now)
    );

endmodule

@@ tb/sv/tb_ddsm_checker.sv @@
// Result checker for the differential-drive servo mixer testbench.
// Mirrors the mixer's registers, timer and wheel arithmetic from the observed channels.
// Depends on ddsm_pkg.
`timescale 1ns / 100ps

module tb_ddsm_checker #(
    parameter int BUS_MODE = 0
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [ddsm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ddsm_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic                                action,
    input  logic signed [ddsm_pkg::SPEED_W-1:0] linear_speed,
    input  logic signed [ddsm_pkg::SPEED_W-1:0] turn_rate,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic signed [ddsm_pkg::DRIVE_W-1:0] left_drive,
    input  logic signed [ddsm_pkg::DRIVE_W-1:0] right_drive,
    input  logic                                enabled,
    input  logic                                stopped_now,
    output int                                  mismatches,
    output int                                  pending,
    output int                                  result_count,
    output int                                  stop_count
);
    import ddsm_pkg::*;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] left;
        logic signed [DRIVE_W-1:0] right;
        logic                      enabled;
        logic                      stopped;
    } drive_t;

    localparam drive_t STOP_DRIVE = '{left: '0, right: '0, enabled: 1'b0, stopped: 1'b1};

    cfg_t                 regs;
    logic                 armed;
    logic [ELAPSED_W-1:0] elapsed;
    logic                 attached;
    drive_t               drive_q[$];

    function automatic longint clamp(input longint x, input longint lo, input longint hi);
        if (x < lo)
            return lo;
        if (x > hi)
            return hi;
        return x;
    endfunction

    task automatic push_stop();
        if (BUS_MODE == 0)
            attached = 1'b0;
        drive_q.push_back(STOP_DRIVE);
    endtask

    task automatic mix_command(input logic signed [SPEED_W-1:0] lin_in,
                               input logic signed [SPEED_W-1:0] turn_in);
        longint lin;
        longint ang;
        longint off_l;
        longint off_r;
        drive_t d;
        armed   = 1'b1;
        elapsed = '0;
        lin = longint'(lin_in) * longint'(regs.linear_gain);
        ang = longint'(turn_in) * longint'(regs.angular_gain);
        // Integer division truncates toward zero, which is the shift the mixer wants.
        off_l = (lin - ang) / 64'sd1048576;
        off_r = (lin + ang) / 64'sd1048576;
        if (BUS_MODE != 0)
        begin
            d.left    = DRIVE_W'(clamp(off_l, -BUS_LIMIT, BUS_LIMIT));
            d.right   = DRIVE_W'(clamp(-off_r, -BUS_LIMIT, BUS_LIMIT));
            d.enabled = 1'b1;
            d.stopped = 1'b0;
            drive_q.push_back(d);
            return;
        end
        if ((off_l < 0 ? -off_l : off_l) < longint'(regs.dead_band))
            off_l = 0;
        if ((off_r < 0 ? -off_r : off_r) < longint'(regs.dead_band))
            off_r = 0;
        if (off_l == 0 && off_r == 0)
        begin
            push_stop();
            return;
        end
        attached  = 1'b1;
        d.left    = DRIVE_W'(clamp(longint'(regs.left_center) + off_l,
                                   longint'(regs.pulse_min), longint'(regs.pulse_max)));
        d.right   = DRIVE_W'(clamp(longint'(regs.right_center) - off_r,
                                   longint'(regs.pulse_min), longint'(regs.pulse_max)));
        d.enabled = 1'b1;
        d.stopped = 1'b0;
        drive_q.push_back(d);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs = '{linear_gain: 16'd256, angular_gain: 16'd256,
                     left_center: 12'd1500, right_center: 12'd1500,
                     dead_band: 8'd0, pulse_min: 12'd1000, pulse_max: 12'd2000,
                     timeout_ticks: 16'd500};
            armed        = 1'b0;
            elapsed      = '0;
            attached     = 1'b1;
            drive_q.delete();
            mismatches   = 0;
            pending      = 0;
            result_count = 0;
            stop_count   = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_LINEAR_GAIN:   regs.linear_gain   = cfg_data;
                    REG_ANGULAR_GAIN:  regs.angular_gain  = cfg_data;
                    REG_LEFT_CENTER:   regs.left_center   = cfg_data[PULSE_W-1:0];
                    REG_RIGHT_CENTER:  regs.right_center  = cfg_data[PULSE_W-1:0];
                    REG_DEAD_BAND:     regs.dead_band     = cfg_data[BAND_W-1:0];
                    REG_PULSE_MIN:     regs.pulse_min     = cfg_data[PULSE_W-1:0];
                    REG_PULSE_MAX:     regs.pulse_max     = cfg_data[PULSE_W-1:0];
                    REG_TIMEOUT_TICKS: regs.timeout_ticks = cfg_data;
                    default: ;
                endcase
            end

            if (out_valid && !out_stall)
            begin : take_result
                drive_t got;
                drive_t want;
                got = '{left: left_drive, right: right_drive,
                        enabled: enabled, stopped: stopped_now};
                result_count++;
                if (stopped_now)
                    stop_count++;
                if (drive_q.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result left=%0d right=%0d enabled=%0b stop=%0b",
                             $time, left_drive, right_drive, enabled, stopped_now);
                end
                else
                begin
                    want = drive_q.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        $display("%0t: mismatch expected left=%0d right=%0d enabled=%0b stop=%0b",
                                 $time, $signed(want.left), $signed(want.right),
                                 want.enabled, want.stopped);
                        $display("%0t:          actual   left=%0d right=%0d enabled=%0b stop=%0b",
                                 $time, left_drive, right_drive, enabled, stopped_now);
                    end
                end
            end

            if (in_valid && !in_stall)
            begin
                if (action)
                begin
                    // A tick only matters while a command has armed the timer.
                    if (armed)
                    begin
                        if (elapsed != '1)
                            elapsed++;
                        if (elapsed > {1'b0, regs.timeout_ticks})
                        begin
                            armed = 1'b0;
                            push_stop();
                        end
                    end
                end
                else
                begin
                    mix_command(linear_speed, turn_rate);
                end
            end

            pending = drive_q.size();
        end
    end

endmodule

@@ tb/sv/tb_diff_drive_servo_mixer.sv @@
// Top of the differential-drive servo mixer testbench: clock, reset, stimulus and verdict.
// Depends on ddsm_pkg, the mixer RTL and tb_ddsm_checker, which predicts and compares.
`timescale 1ns / 100ps

module tb_diff_drive_servo_mixer;
    import ddsm_pkg::*;

    localparam int BUS_MODE      = SERIAL_BUS_MODE_DEFAULT;
    // Random items to reach, spread over PHASES register settings.
    localparam int RANDOM_ITEMS  = 1300;
    localparam int PHASES        = 8;
    // A tick that gives no result can still be in flight after the last result has come
    // back, so drain waits this long before going on.
    localparam int SETTLE_CYCLES = 10;
    // Far beyond the slowest run, even with the longest idle gaps and stalls on every item.
    localparam int RUN_LIMIT_NS  = 5_000_000;

    logic                       clk          = 1'b0;
    logic                       rst_n        = 1'b0;
    logic                       cfg_write    = 1'b0;
    logic [CFG_INDEX_W-1:0]     cfg_index    = '0;
    logic [CFG_DATA_W-1:0]      cfg_data     = '0;
    logic                       in_valid     = 1'b0;
    logic                       in_stall;
    logic                       action       = 1'b0;
    logic signed [SPEED_W-1:0]  linear_speed = '0;
    logic signed [SPEED_W-1:0]  turn_rate    = '0;
    logic                       out_valid;
    logic                       out_stall    = 1'b0;
    logic signed [DRIVE_W-1:0]  left_drive;
    logic signed [DRIVE_W-1:0]  right_drive;
    logic                       enabled;
    logic                       stopped_now;

    int mismatches;
    int pending;
    int result_count;
    int stop_count;

    // When quiet is set, neither side idles, which gives back-to-back stretches.
    bit quiet     = 1'b0;
    int out_hold  = 0;
    int sent      = 0;
    int counted   = 0;
    int settings  = 0;

    diff_drive_servo_mixer #(
        .SERIAL_BUS_MODE(BUS_MODE)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .linear_speed (linear_speed),
        .turn_rate    (turn_rate),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .left_drive   (left_drive),
        .right_drive  (right_drive),
        .enabled      (enabled),
        .stopped_now  (stopped_now)
    );

    tb_ddsm_checker #(
        .BUS_MODE(BUS_MODE)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .linear_speed (linear_speed),
        .turn_rate    (turn_rate),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .left_drive   (left_drive),
        .right_drive  (right_drive),
        .enabled      (enabled),
        .stopped_now  (stopped_now),
        .mismatches   (mismatches),
        .pending      (pending),
        .result_count (result_count),
        .stop_count   (stop_count)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Hard stop in case the mixer hangs.
    initial
    begin
        #RUN_LIMIT_NS;
        $display("tb: failure");
        $finish;
    end

    function automatic int draw_gap();
        return quiet ? 0 : $urandom_range(0, 9);
    endfunction

    // Receiver side: after each accepted result, stall for a freshly drawn number of
    // cycles. Stall is driven at the falling edge and the hold count is refreshed at
    // the rising edge, so the two processes never touch it in the same time step.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            out_hold <= draw_gap();
    end

    always @(negedge clk)
    begin
        if (out_hold > 0)
        begin
            out_stall <= 1'b1;
            out_hold  <= out_hold - 1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // Offers one item after a random idle gap and holds it until the mixer takes it.
    // The payload is left alone while the item is stalled.
    task automatic send_item(input logic act, input logic [SPEED_W-1:0] lin,
                             input logic [SPEED_W-1:0] turn);
        int gap;
        gap = draw_gap();
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid     <= 1'b1;
        action       <= act;
        linear_speed <= lin;
        turn_rate    <= turn;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent++;
    endtask

    task automatic send_tick();
        send_item(1'b1, 16'($urandom), 16'($urandom));
    endtask

    // Stops sending and waits until every predicted result has come back, then lets
    // any result-free tick leave the pipeline. Registers are only written after this.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
    endtask

    // Every register is written on each change of setting.
    task automatic load_config(input cfg_t c);
        write_reg(REG_LINEAR_GAIN,   c.linear_gain);
        write_reg(REG_ANGULAR_GAIN,  c.angular_gain);
        write_reg(REG_LEFT_CENTER,   c.left_center);
        write_reg(REG_RIGHT_CENTER,  c.right_center);
        write_reg(REG_DEAD_BAND,     c.dead_band);
        write_reg(REG_PULSE_MIN,     c.pulse_min);
        write_reg(REG_PULSE_MAX,     c.pulse_max);
        write_reg(REG_TIMEOUT_TICKS, c.timeout_ticks);
        @(negedge clk);
        cfg_write <= 1'b0;
        settings++;
    endtask

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return '1;
            2:       return 16'd256;
            3:       return 16'($urandom_range(1, 8192));
            default: return 16'($urandom);
        endcase
    endfunction

    // Speeds lean toward the extremes and toward small values, where the dead band
    // and the both-offsets-zero stop live.
    function automatic logic [SPEED_W-1:0] pick_speed();
        case ($urandom_range(0, 5))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return '0;
            3:       return 16'(int'($urandom_range(0, 600)) - 300);
            default: return 16'($urandom);
        endcase
    endfunction

    // Setting zero puts every register at its top, setting one all but the angular gain at its
    // bottom; the rest are random, with inverted pulse limits now and then. Short timeouts, long
    // only in the last setting, keep the tick bursts brief while still expiring often.
    function automatic cfg_t rand_config(input int phase);
        cfg_t c;
        int   a;
        int   b;
        int   t;
        bit   inverted;
        c.linear_gain  = pick_gain();
        c.angular_gain = pick_gain();
        c.left_center  = 12'($urandom_range(500, 2500));
        c.right_center = 12'($urandom_range(500, 2500));
        case ($urandom_range(0, 2))
            0:       c.dead_band = '0;
            1:       c.dead_band = '1;
            default: c.dead_band = 8'($urandom_range(0, 255));
        endcase
        a        = $urandom_range(500, 2500);
        b        = $urandom_range(500, 2500);
        inverted = ($urandom_range(0, 5) == 0);
        if ((a > b) != inverted)
        begin
            t = a;
            a = b;
            b = t;
        end
        c.pulse_min     = 12'(a);
        c.pulse_max     = 12'(b);
        c.timeout_ticks = 16'($urandom_range(0, 15));
        if (phase == PHASES - 1)
            c.timeout_ticks = 16'($urandom_range(1000, 65535));
        if (phase == 0)
            c = '{linear_gain: '1, angular_gain: '1, left_center: 12'd2500,
                  right_center: 12'd2500, dead_band: '1, pulse_min: 12'd2500,
                  pulse_max: 12'd2500, timeout_ticks: '1};
        if (phase == 1)
        begin
            c.linear_gain   = '0;
            c.left_center   = 12'd500;
            c.right_center  = 12'd500;
            c.dead_band     = '0;
            c.pulse_min     = 12'd500;
            c.pulse_max     = 12'd500;
            c.timeout_ticks = '0;
        end
        return c;
    endfunction

    // One random sequence: mostly a command followed by a burst of ticks that often
    // runs past the timeout, sometimes a stray tick as noise. Only items the mixer
    // acts on count toward the random total.
    task automatic run_sequence(input cfg_t c);
        int n;
        int lim;
        quiet = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 9) == 0)
        begin
            send_tick();
        end
        else
        begin
            lim = (c.timeout_ticks > 36) ? 40 : int'(c.timeout_ticks) + 3;
            n   = $urandom_range(0, lim);
            send_item(1'b0, pick_speed(), pick_speed());
            for (int k = 0; k < n; k++)
                send_tick();
            counted += 1 + ((n > int'(c.timeout_ticks) + 1) ? int'(c.timeout_ticks) + 1 : n);
        end
    endtask

    initial
    begin
        cfg_t c;

        repeat (6)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset values first: a tick before any command is ignored, a zero command
        // detaches with a stop, and small offsets ride on the 1500 us neutral.
        send_tick();
        send_item(1'b0, 16'sd0, 16'sd0);
        send_item(1'b0, 16'sh7FFF, 16'sd0);
        send_item(1'b0, 16'sh8000, 16'sh8000);
        send_item(1'b0, 16'sh7FFF, 16'sh8000);
        send_tick();
        drain();

        // Full-scale gains, the widest dead band and the pulse extremes. Small speeds
        // fall inside the dead band; one wheel can be banded while the other drives.
        // A zero timeout stops on the first tick, and the next tick finds the timer off.
        c = '{linear_gain: '1, angular_gain: '1, left_center: 12'd500,
              right_center: 12'd2500, dead_band: '1, pulse_min: 12'd500,
              pulse_max: 12'd2500, timeout_ticks: '0};
        load_config(c);
        send_item(1'b0, 16'sh7FFF, 16'sh7FFF);
        send_item(1'b0, 16'sh8000, 16'sh7FFF);
        send_item(1'b0, 16'sd100, -16'sd100);
        send_item(1'b0, 16'sd4000, 16'sd0);
        send_item(1'b0, 16'sd4200, 16'sd0);
        send_item(1'b0, 16'sd4200, 16'sd4100);
        send_tick();
        send_tick();
        drain();

        // Zero gains turn every command into a stop.
        c.linear_gain  = '0;
        c.angular_gain = '0;
        c.dead_band    = '0;
        load_config(c);
        send_item(1'b0, 16'sh7FFF, 16'sh8000);
        send_item(1'b0, 16'sh8000, 16'sh7FFF);
        drain();

        // Inverted pulse limits: below the minimum gives the minimum, anything else
        // above the maximum gives the maximum. The third tick expires a timeout of two.
        c = '{linear_gain: 16'd4096, angular_gain: 16'd4096, left_center: 12'd1500,
              right_center: 12'd1500, dead_band: '0, pulse_min: 12'd2000,
              pulse_max: 12'd1000, timeout_ticks: 16'd2};
        load_config(c);
        send_item(1'b0, 16'sd8192, 16'sd0);
        send_item(1'b0, 16'sh8000, 16'sd0);
        send_item(1'b0, 16'sd1024, 16'sd8192);
        send_tick();
        send_tick();
        send_tick();
        send_tick();
        drain();

        // Random part. Each drain also makes the sender wait for every result.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            c = rand_config(phase);
            load_config(c);
            while (counted < (phase + 1) * RANDOM_ITEMS / PHASES)
                run_sequence(c);
            drain();
        end

        $display("Run covered %0d items under %0d register settings, in %s mode.",
                 sent, settings, (BUS_MODE != 0) ? "serial-bus" : "PWM");
        $display("Checked %0d results, %0d of them stops, with %0d mismatches.",
                 result_count, stop_count, mismatches);
        if (mismatches == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
